// File: rtl/masked_byte_signature_scan_top_macros.svh
// Assertion macros shared by the RTL files of the signature scanner.
`ifndef MASKED_BYTE_SIGNATURE_SCAN_TOP_MACROS_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

    // Pattern storage. The window ring is indexed by the low bits of the
    // byte position, so the capacity is a power of two.
    localparam int PATTERN_MAX  = 128;
    localparam int PAT_AW       = $clog2(PATTERN_MAX);
    localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
    localparam int OFFSET_WIDTH = 32;
    localparam int OUT_OFF_W    = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SCAN   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NONE    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       care;
        logic [7:0] value;
    } t_pat_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_check;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/mbss_dpath.sv
`timescale 1ns / 1ps
`include "masked_byte_signature_scan_top_macros.svh"

module mbss_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbss_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_byte_value,
    input  logic              i_care,
    output mbss_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [31:0]       o_match_offset
);
    import mbss_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

    // Pattern and window memories.
    t_pat_entry r_pat_mem [PATTERN_MAX];
    logic [7:0] r_win_mem [PATTERN_MAX];

    // Pattern and region state.
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_ovf, n_ovf;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic                    r_found, n_found;
    logic [OFFSET_WIDTH-1:0] r_first, n_first;

    // Compare sequencer state.
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [PAT_AW-1:0] r_base, n_base;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_cmp_last, n_cmp_last;
    t_pat_entry        r_pat_q;
    logic [7:0]        r_win_q;

    // Result register.
    logic                 r_out_vld, n_out_vld;
    logic [1:0]           r_out_status, n_out_status;
    logic [OUT_OFF_W-1:0] r_out_off, n_out_off;

    logic                    w_is_scan;
    logic                    w_is_append;
    logic                    w_is_clear;
    logic                    w_sat;
    logic [OFFSET_WIDTH-1:0] w_count;
    logic [OFFSET_WIDTH-1:0] w_len_ext;
    logic                    w_win_wr;
    logic                    w_pat_wr;
    logic                    w_start;
    logic                    w_iss;
    logic [PAT_AW-1:0]       w_slot;
    logic                    w_cmp_ok;

    // Decode of the accepted request.
    assign w_is_clear  = (i_opcode == OP_CLEAR);
    assign w_is_append = (i_opcode == OP_APPEND);
    assign w_is_scan   = (i_opcode == OP_SCAN);
    assign w_sat       = (r_pos == POS_MAX);
    assign w_count     = r_pos + OFFSET_WIDTH'(1);
    assign w_len_ext   = OFFSET_WIDTH'(r_len);
    assign w_win_wr    = i_cmd.accept && w_is_scan && !w_sat;
    assign w_pat_wr    = i_cmd.accept && w_is_append && (r_len < LEN_W'(PATTERN_MAX));

    // A window check is due when no match is recorded yet and the pattern fits.
    assign o_stat.need_check = w_is_scan && !w_sat && !r_found && (r_len != '0) &&
                               !r_ovf && (w_count >= w_len_ext);
    assign w_start = i_cmd.accept && o_stat.need_check;

    // One pattern entry and one window byte are read per cycle.
    assign w_iss    = i_cmd.scan && (r_idx < r_len);
    assign w_slot   = r_base + r_idx[PAT_AW-1:0];
    assign w_cmp_ok = !r_pat_q.care || (r_win_q == r_pat_q.value);

    assign o_stat.hit      = i_cmd.scan && r_cmp_vld && w_cmp_ok && r_cmp_last;
    assign o_stat.miss     = i_cmd.scan && r_cmp_vld && !w_cmp_ok;
    assign o_stat.out_free = !r_out_vld || i_ready;

    // Next-state logic of the datapath registers.
    always_comb begin
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_pos        = r_pos;
        n_found      = r_found;
        n_first      = r_first;
        n_idx        = r_idx;
        n_base       = r_base;
        n_cmp_vld    = w_iss;
        n_cmp_last   = (r_idx == (r_len - LEN_W'(1)));
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_off    = r_out_off;

        if (i_cmd.accept && w_is_clear) begin
            n_len = '0;
            n_ovf = 1'b0;
        end
        if (i_cmd.accept && w_is_append) begin
            if (w_pat_wr) begin
                n_len = r_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (w_win_wr) begin
            n_pos = w_count;
        end
        if (w_start) begin
            n_idx     = '0;
            n_base    = w_count[PAT_AW-1:0] - r_len[PAT_AW-1:0];
            n_cmp_vld = 1'b0;
        end else if (w_iss) begin
            n_idx = r_idx + LEN_W'(1);
        end
        if (o_stat.hit) begin
            n_found = 1'b1;
            n_first = r_pos - w_len_ext;
        end

        // The result slot empties when taken and is loaded at region end.
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_vld = 1'b1;
            if ((r_len == '0) || r_ovf) begin
                n_out_status = ST_INVALID;
                n_out_off    = '0;
            end else if (r_found) begin
                n_out_status = ST_FOUND;
                n_out_off    = OUT_OFF_W'(r_first);
            end else begin
                n_out_status = ST_NONE;
                n_out_off    = '0;
            end
            n_pos   = '0;
            n_found = 1'b0;
            n_first = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_pos     <= '0;
            r_found   <= 1'b0;
            r_first   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_pos     <= n_pos;
            r_found   <= n_found;
            r_first   <= n_first;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_cmp_last   <= n_cmp_last;
        r_out_status <= n_out_status;
        r_out_off    <= n_out_off;
    end

    // Pattern memory port.
    always_ff @(posedge i_clk) begin
        if (w_pat_wr) begin
            r_pat_mem[r_len[PAT_AW-1:0]] <= '{care: i_care, value: i_byte_value};
        end
        if (w_iss) begin
            r_pat_q <= r_pat_mem[r_idx[PAT_AW-1:0]];
        end
    end

    // Window ring memory port.
    always_ff @(posedge i_clk) begin
        if (w_win_wr) begin
            r_win_mem[r_pos[PAT_AW-1:0]] <= i_byte_value;
        end
        if (w_iss) begin
            r_win_q <= r_win_mem[w_slot];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_status;
    assign o_match_offset = r_out_off;

    // A result is only loaded into a free slot.
    `MBSS_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, i_cmd.emit, o_stat.out_free)
    // Loading a result clears the region.
    `MBSS_ASSERT_NEXT(a_emit_clear, i_clk, i_rst_n, i_cmd.emit,
                      r_out_vld && (r_pos == '0) && !r_found)
    // A full-length match is recorded.
    `MBSS_ASSERT_NEXT(a_hit_found, i_clk, i_rst_n, o_stat.hit, r_found)
    // The pattern length never exceeds capacity.
    `MBSS_ASSERT_SAME(a_len_cap, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(PATTERN_MAX))

endmodule

// File: rtl/mbss_ctrl.sv
`timescale 1ns / 1ps
`include "masked_byte_signature_scan_top_macros.svh"

module mbss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic               i_region_end,
    input  mbss_pkg::t_dp_stat i_stat,
    output mbss_pkg::t_dp_cmd  o_cmd
);
    import mbss_pkg::*;

    t_state r_state, n_state;
    logic   r_last, n_last;

    // State register and the region-end flag of the byte being checked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        n_last       = r_last;
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.emit   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == OP_SCAN) begin
                        n_last = i_region_end;
                        if (i_stat.need_check) begin
                            n_state = S_SCAN;
                        end else if (i_region_end) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.miss) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Requests are taken only while no check or result load is pending.
    `MBSS_ASSERT_SAME(a_accept_idle, i_clk, i_rst_n, o_cmd.accept,
                      (r_state == S_IDLE) && !o_cmd.scan && !o_cmd.emit)
    // A compare ends the check in the next cycle.
    `MBSS_ASSERT_NEXT(a_scan_exit, i_clk, i_rst_n, o_cmd.scan && (i_stat.hit || i_stat.miss),
                      r_state != S_SCAN)
    // A result load returns to idle.
    `MBSS_ASSERT_NEXT(a_emit_idle, i_clk, i_rst_n, o_cmd.emit, r_state == S_IDLE)

endmodule

// File: rtl/masked_byte_signature_scan_top.sv
`timescale 1ns / 1ps

// Wildcard byte pattern search. Clear, append and data requests share one input
// channel; a data request with region_end set yields one result (found with the
// offset of the first match, not found, or invalid pattern) on the output channel.
// A clear or append request needs no more work once taken, nor does a data
// byte that needs no window check (a match already recorded, the region still
// shorter than the pattern, an invalid pattern, or a saturated position). A
// data byte that needs a check holds off the input until the window matches or
// the first mismatching pattern entry is found: the check walks the pattern
// memory and the window ring one entry per cycle through their registered read
// ports. The last byte of a region then loads the result register, waiting
// while an earlier result is still held. The input stays open while a result
// waits to be taken. Pattern and window memories need no clearing after reset.
module masked_byte_signature_scan_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic        i_care,
    input  logic        i_region_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_match_offset
);
    import mbss_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    mbss_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_region_end (i_region_end),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    // Pattern store, window ring, comparator and result register.
    mbss_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_opcode),
        .i_byte_value   (i_byte_value),
        .i_care         (i_care),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_match_offset (o_match_offset)
    );

endmodule
